/* hdl/ialu_pkg.sv */
// Package for the signed integer ALU: operation and status codes, control bundle
// carried from cell to cell along the pipeline.
// No dependencies.
package ialu_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_REM = 3'd4,
        OP_POW = 3'd5,
        OP_UN6 = 3'd6,
        OP_UN7 = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_DIV_ZERO     = 2'd1,
        ST_UNSUPPORTED  = 2'd2,
        ST_ZERO_NEG_POW = 2'd3
    } status_t;

    // control that travels alongside each item
    typedef struct packed {
        logic    vld;
        op_t     op;
        logic    neg_q;    // negate quotient at the end
        logic    neg_r;    // negate remainder at the end
        logic    fixed;    // result already settled at entry
        status_t st;
    } ctl_t;

endpackage

/* hdl/ialu_cell.sv */
// One pipeline cell: one restoring-division step or one square-and-multiply step.
// Depends on ialu_pkg.
module ialu_cell #(
    parameter int W = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  ialu_pkg::ctl_t  ctl_in,
    input  logic [W-1:0]    rem_in,   // partial remainder / power accumulator
    input  logic [W-1:0]    quo_in,   // dividend bits then quotient / exponent
    input  logic [W-1:0]    div_in,   // divisor magnitude / power base
    output ialu_pkg::ctl_t  ctl_out,
    output logic [W-1:0]    rem_out,
    output logic [W-1:0]    quo_out,
    output logic [W-1:0]    div_out
);
    ialu_pkg::ctl_t ctl_reg;
    logic [W-1:0]   rem_reg, quo_reg, div_reg;
    logic [W-1:0]   rem_next, quo_next, div_next;
    logic [W:0]     trial;
    logic [W:0]     diff;
    logic           is_pow;

    always_comb
    begin
        is_pow   = (ctl_in.op == ialu_pkg::OP_POW);
        trial    = {rem_in, quo_in[W-1]};
        diff     = trial - {1'b0, div_in};
        rem_next = rem_in;
        quo_next = quo_in;
        div_next = div_in;
        if (ctl_in.fixed)
        begin
            rem_next = rem_in;
        end
        else if (is_pow)
        begin
            // exponent consumed LSB first: acc times base if bit set, base squared
            if (quo_in[0])
                rem_next = W'(rem_in * div_in);
            div_next = W'(div_in * div_in);
            quo_next = {1'b0, quo_in[W-1:1]};
        end
        else
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_in[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_in[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            div_reg <= div_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign div_out = div_reg;
endmodule

/* hdl/integer_alu_with_power.sv */
// Top level of the signed integer ALU: entry stage, chain of DATA_WIDTH cells, output stage.
// Depends on ialu_pkg and ialu_cell.
//
//  channel | dir | fields (low bit first)
//  s_axis  | in  | tdata: kind[2:0], lhs, rhs (zero padded)
//  m_axis  | out | tdata: value, status (zero padded)
//
// Results pass through the cell chain and then the output register; one item per
// cycle while the output is not stalled (one quotient or exponent bit per cell).
// Reset clears the valid flags of all stages; payload is not reset.
// The whole pipeline advances together when the output register is empty
// or is being taken; tready follows that.
module integer_alu_with_power #(
    parameter int DATA_WIDTH = 32,
    localparam int IN_BYTES  = (3 + 2*DATA_WIDTH + 7) / 8,
    localparam int OUT_BYTES = (DATA_WIDTH + 2 + 7) / 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_BYTES*8-1:0]  s_axis_tdata,   // kind, lhs, rhs
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_BYTES*8-1:0] m_axis_tdata    // value, status
);
    localparam int W = DATA_WIDTH;

    logic        en;
    ialu_pkg::op_t kind;
    logic [W-1:0] lhs, rhs, mag_a, mag_b;

    ialu_pkg::ctl_t ent_ctl;
    logic [W-1:0]   ent_rem, ent_quo, ent_div;

    ialu_pkg::ctl_t ctl_c [0:W];
    logic [W-1:0]   rem_c [0:W];
    logic [W-1:0]   quo_c [0:W];
    logic [W-1:0]   div_c [0:W];

    logic           out_vld_reg;
    logic [W-1:0]   out_val_reg, val_next;
    ialu_pkg::status_t out_st_reg;

    assign kind = ialu_pkg::op_t'(s_axis_tdata[2:0]);
    assign lhs  = s_axis_tdata[3 +: W];
    assign rhs  = s_axis_tdata[3+W +: W];
    assign mag_a = lhs[W-1] ? W'(-lhs) : lhs;
    assign mag_b = rhs[W-1] ? W'(-rhs) : rhs;

    // pipeline moves when the output slot frees up
    assign en = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // entry: classify the op, settle trivial cases, load the first cell
    always_comb
    begin
        ent_ctl       = '0;
        ent_ctl.vld   = s_axis_tvalid;
        ent_ctl.op    = kind;
        ent_ctl.st    = ialu_pkg::ST_OK;
        ent_rem       = '0;
        ent_quo       = mag_a;
        ent_div       = mag_b;
        unique case (kind)
            ialu_pkg::OP_ADD:
            begin
                ent_ctl.fixed = 1'b1;
                ent_rem       = W'(lhs + rhs);
            end
            ialu_pkg::OP_SUB:
            begin
                ent_ctl.fixed = 1'b1;
                ent_rem       = W'(lhs - rhs);
            end
            ialu_pkg::OP_MUL:
            begin
                // low product: accumulator a times base b, exponent 1, via the power path
                ent_ctl.op = ialu_pkg::OP_POW;
                ent_rem    = lhs;
                ent_quo    = W'(1);
                ent_div    = rhs;
            end
            ialu_pkg::OP_DIV, ialu_pkg::OP_REM:
            begin
                ent_ctl.neg_q = lhs[W-1] ^ rhs[W-1];
                ent_ctl.neg_r = lhs[W-1];
                if (rhs == '0)
                begin
                    ent_ctl.fixed = 1'b1;
                    ent_ctl.st    = ialu_pkg::ST_DIV_ZERO;
                end
            end
            ialu_pkg::OP_POW:
            begin
                ent_rem = W'(1);
                ent_quo = rhs;
                ent_div = lhs;
                if (rhs[W-1])
                begin
                    ent_ctl.fixed = 1'b1;
                    if (lhs == W'(1))
                        ent_rem = W'(1);
                    else if (lhs == '1)
                        ent_rem = rhs[0] ? '1 : W'(1);
                    else if (lhs == '0)
                    begin
                        ent_rem    = '0;
                        ent_ctl.st = ialu_pkg::ST_ZERO_NEG_POW;
                    end
                    else
                        ent_rem = '0;
                end
            end
            default:
            begin
                ent_ctl.fixed = 1'b1;
                ent_ctl.st    = ialu_pkg::ST_UNSUPPORTED;
            end
        endcase
    end

    assign ctl_c[0] = ent_ctl;
    assign rem_c[0] = ent_rem;
    assign quo_c[0] = ent_quo;
    assign div_c[0] = ent_div;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        ialu_cell #(.W(W)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_c[i]),
            .rem_in  (rem_c[i]),
            .quo_in  (quo_c[i]),
            .div_in  (div_c[i]),
            .ctl_out (ctl_c[i+1]),
            .rem_out (rem_c[i+1]),
            .quo_out (quo_c[i+1]),
            .div_out (div_c[i+1])
        );
    end

    // finish: sign fix for div/rem, zero on error
    always_comb
    begin
        val_next = rem_c[W];
        if (!ctl_c[W].fixed)
        begin
            if (ctl_c[W].op == ialu_pkg::OP_DIV)
                val_next = ctl_c[W].neg_q ? W'(-quo_c[W]) : quo_c[W];
            else if (ctl_c[W].op == ialu_pkg::OP_REM)
                val_next = ctl_c[W].neg_r ? W'(-rem_c[W]) : rem_c[W];
        end
        if (ctl_c[W].st != ialu_pkg::ST_OK)
            val_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= ctl_c[W].vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_val_reg <= val_next;
            out_st_reg  <= ctl_c[W].st;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = (OUT_BYTES*8)'({out_st_reg, out_val_reg});

`ifndef SYNTHESIS
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("ready while output stalled");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_st_reg != ialu_pkg::ST_OK) |-> (out_val_reg == '0))
        else $error("nonzero value with error status");
`endif
endmodule
